FILE: hw/rtl/scan_breakpoint_clustering_unit_macros.svh
// assertion macros for the scan breakpoint clustering unit
// used by the port checker; no other dependencies
`ifndef SCAN_BREAKPOINT_CLUSTERING_UNIT_MACROS_SVH
`define SCAN_BREAKPOINT_CLUSTERING_UNIT_MACROS_SVH

// generic clocked assertion with asynchronous active-low reset
`define SBC_ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sbc check failed");

// assertion on the unit clock and reset
`define SBC_ASSERT(label, prop) `SBC_ASSERT_CLK(label, clk, arst_n, prop)

`endif

FILE: hw/rtl/sbc_pkg.sv
// shared types and constants of the scan breakpoint clustering unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

	localparam int COORD_W    = 16;
	localparam int SQ_W       = 32;
	localparam int NUM_W      = 10;
	localparam int COUNT_W    = 12;
	localparam int MAX_POINTS = 2048;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam logic [COORD_W-1:0] GAP_RESET = 16'd256;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;
	localparam int CRED_W = QCNT_W + 1;

	// classified point handed from front to back
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
		logic                      first;
		logic                      brk;
	} sbc_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sbc_front.sv
// front part: accepts points, squares the gap to the previous point and
// flags breakpoints; depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbc_front import sbc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       gap_threshold_we,
	input  wire logic [COORD_W-1:0]         gap_threshold,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [COORD_W-1:0]  point_x,
	input  wire logic signed [COORD_W-1:0]  point_y,
	input  wire logic                       scan_last,
	input  wire logic [QCNT_W-1:0]          q_count,
	output logic                            push,
	output sbc_item_t                       push_item
);

	logic                      accept;
	logic [SQ_W-1:0]           thr_sq;
	logic [SQ_W-1:0]           thr_sq_q;
	logic signed [COORD_W-1:0] prev_x_q;
	logic signed [COORD_W-1:0] prev_y_q;
	logic                      first_q;
	logic signed [COORD_W:0]   dx;
	logic signed [COORD_W:0]   dy;
	logic signed [2*COORD_W+1:0] sqx;
	logic signed [2*COORD_W+1:0] sqy;
	logic [CRED_W-1:0]         in_flight;
	logic [SQ_W:0]             d2;

	logic                      v_s1;
	logic signed [COORD_W-1:0] x_s1;
	logic signed [COORD_W-1:0] y_s1;
	logic                      last_s1;
	logic                      first_s1;
	logic [SQ_W-1:0]           sqx_s1;
	logic [SQ_W-1:0]           sqy_s1;

	logic                      v_s2;
	sbc_item_t                 item_s2;

	// credit: queue entries plus items still in the two stages
	assign in_flight = CRED_W'(q_count) + CRED_W'(v_s1) + CRED_W'(v_s2);
	assign in_ready  = in_flight < CRED_W'(QDEPTH);
	assign accept    = in_valid && in_ready;

	assign thr_sq = {{(SQ_W-COORD_W){1'b0}}, gap_threshold}
		* {{(SQ_W-COORD_W){1'b0}}, gap_threshold};

	assign dx  = {point_x[COORD_W-1], point_x} - {prev_x_q[COORD_W-1], prev_x_q};
	assign dy  = {point_y[COORD_W-1], point_y} - {prev_y_q[COORD_W-1], prev_y_q};
	assign sqx = dx * dx;
	assign sqy = dy * dy;

	assign d2 = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= SQ_W'(GAP_RESET) * SQ_W'(GAP_RESET);
			first_q  <= 1'b1;
			prev_x_q <= '0;
			prev_y_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (gap_threshold_we) begin
				thr_sq_q <= thr_sq;
			end
			if (accept) begin
				prev_x_q <= point_x;
				prev_y_q <= point_y;
				first_q  <= scan_last;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1     <= point_x;
			y_s1     <= point_y;
			last_s1  <= scan_last;
			first_s1 <= first_q;
			sqx_s1   <= sqx[SQ_W-1:0];
			sqy_s1   <= sqy[SQ_W-1:0];
		end
		if (v_s1) begin
			item_s2.x     <= x_s1;
			item_s2.y     <= y_s1;
			item_s2.last  <= last_s1;
			item_s2.first <= first_s1;
			item_s2.brk   <= d2 > {1'b0, thr_sq_q};
		end
	end

	assign push      = v_s2;
	assign push_item = item_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/sbc_queue.sv
// short register queue between front and back parts
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbc_queue import sbc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire sbc_item_t   push_item,
	input  wire logic        pop,
	output logic             q_valid,
	output sbc_item_t        q_item,
	output logic [QCNT_W-1:0] q_count
);

	sbc_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_valid = count_q != '0;
	assign q_item  = mem_q[rd_ptr_q];
	assign q_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sbc_back.sv
// back part: tracks the open cluster, closes it and drives the result register
// depends on sbc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbc_back import sbc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire sbc_item_t                  q_item,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [COORD_W-1:0]       centre_x,
	output logic signed [COORD_W-1:0]       centre_y,
	output logic [NUM_W-1:0]                cluster_number,
	output logic [COUNT_W-1:0]              member_count,
	output logic                            scan_done
);

	logic signed [COORD_W-1:0] head_x_q;
	logic signed [COORD_W-1:0] head_y_q;
	logic signed [COORD_W-1:0] prev_x_q;
	logic signed [COORD_W-1:0] prev_y_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [NUM_W-1:0]          num_q;
	logic                      out_valid_q;

	logic signed [COORD_W-1:0] head_x_n;
	logic signed [COORD_W-1:0] head_y_n;
	logic [CNT_W-1:0]          cnt_n;
	logic [CNT_W-1:0]          cnt_inc;
	logic                      emit_brk;
	logic                      emit_end;
	logic                      emit;
	logic signed [COORD_W-1:0] a_x;
	logic signed [COORD_W-1:0] a_y;
	logic signed [COORD_W-1:0] b_x;
	logic signed [COORD_W-1:0] b_y;
	logic [CNT_W-1:0]          res_cnt;
	logic signed [COORD_W:0]   sum_x;
	logic signed [COORD_W:0]   sum_y;

	assign pop     = q_valid && (!out_valid_q || out_ready);
	assign cnt_inc = (cnt_q < CNT_W'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		head_x_n = head_x_q;
		head_y_n = head_y_q;
		cnt_n    = cnt_inc;
		emit_brk = 1'b0;
		emit_end = 1'b0;
		a_x      = head_x_q;
		a_y      = head_y_q;
		b_x      = prev_x_q;
		b_y      = prev_y_q;
		res_cnt  = cnt_q;
		if (q_item.first || q_item.brk) begin
			// a breakpoint reports the old cluster if it holds two points or more and opens a new one
			emit_brk = !q_item.first && (cnt_q >= CNT_W'(2));
			head_x_n = q_item.x;
			head_y_n = q_item.y;
			cnt_n    = CNT_W'(1);
		end
		if (q_item.last && !emit_brk) begin
			// end of scan flushes the open cluster, ending at this point
			emit_end = cnt_n >= CNT_W'(2);
			a_x      = head_x_n;
			a_y      = head_y_n;
			b_x      = q_item.x;
			b_y      = q_item.y;
			res_cnt  = cnt_n;
		end
		emit = emit_brk || emit_end;
	end

	// midpoint rounds toward minus infinity
	assign sum_x = {a_x[COORD_W-1], a_x} + {b_x[COORD_W-1], b_x};
	assign sum_y = {a_y[COORD_W-1], a_y} + {b_y[COORD_W-1], b_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			num_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result only loads when the register is free or leaving
			out_valid_q <= (pop && emit) || (out_valid_q && !out_ready);
			if (pop) begin
				if (q_item.last) begin
					cnt_q <= '0;
					num_q <= '0;
				end else begin
					cnt_q <= cnt_n;
					num_q <= emit ? num_q + 1'b1 : num_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_x_q <= head_x_n;
			head_y_q <= head_y_n;
			prev_x_q <= q_item.x;
			prev_y_q <= q_item.y;
		end
		if (pop && emit) begin
			centre_x       <= sum_x[COORD_W:1];
			centre_y       <= sum_y[COORD_W:1];
			cluster_number <= num_q;
			member_count   <= COUNT_W'(res_cnt);
			scan_done      <= q_item.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scan_breakpoint_clustering_unit.sv
// scan breakpoint clustering unit: one result per cluster of two points or more
// path: a closing point passes the two front stages, the queue write and the back
// update into the output register; input waits on in_ready, the back on out_ready
// throughput: one item per clock; the back part retires one queued item per cycle
// reset: asynchronous, clears the queue and cluster state, threshold to 256 (1.0 m)
// depends on sbc_pkg, sbc_front, sbc_queue, sbc_back
`timescale 1ns / 1ps
`default_nettype none

module scan_breakpoint_clustering_unit import sbc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       gap_threshold_we,
	input  wire logic [COORD_W-1:0]         gap_threshold,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [COORD_W-1:0]  point_x,
	input  wire logic signed [COORD_W-1:0]  point_y,
	input  wire logic                       scan_last,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [COORD_W-1:0]       centre_x,
	output logic signed [COORD_W-1:0]       centre_y,
	output logic [NUM_W-1:0]                cluster_number,
	output logic [COUNT_W-1:0]              member_count,
	output logic                            scan_done
);

	logic              push;
	sbc_item_t         push_item;
	logic              pop;
	logic              q_valid;
	sbc_item_t         q_item;
	logic [QCNT_W-1:0] q_count;

	sbc_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.gap_threshold_we (gap_threshold_we),
		.gap_threshold    (gap_threshold),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.point_x          (point_x),
		.point_y          (point_y),
		.scan_last        (scan_last),
		.q_count          (q_count),
		.push             (push),
		.push_item        (push_item)
	);

	sbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_count   (q_count)
	);

	sbc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.centre_x       (centre_x),
		.centre_y       (centre_y),
		.cluster_number (cluster_number),
		.member_count   (member_count),
		.scan_done      (scan_done)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/sbc_checker.sv
// port checker for the scan breakpoint clustering unit, bound to the top level
// depends on sbc_pkg and scan_breakpoint_clustering_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "scan_breakpoint_clustering_unit_macros.svh"

module sbc_checker import sbc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_ready,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic signed [COORD_W-1:0]  centre_x,
	input  wire logic signed [COORD_W-1:0]  centre_y,
	input  wire logic [COUNT_W-1:0]         member_count
);

	// a stalled result holds
	`SBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`SBC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(centre_x) && $stable(centre_y))
	// single-point clusters never come out, counts stay saturated
	`SBC_ASSERT(a_count_range, out_valid |-> member_count >= COUNT_W'(2) && member_count <= COUNT_W'(MAX_POINTS))
	// empty queue and stages after reset leave room for an item
	`SBC_ASSERT(a_ready_after_reset, !$past(arst_n) |-> in_ready)

endmodule

bind scan_breakpoint_clustering_unit sbc_checker u_sbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.centre_x     (centre_x),
	.centre_y     (centre_y),
	.member_count (member_count)
);

`default_nettype wire
